[sv/vang_pkg.sv]
// vang_pkg: shared constants, types and the arctangent table for vector_angle_lut
// no dependencies
`timescale 1ns / 1ps

package vang_pkg;

    localparam int COORD_BITS = 16;

    localparam int ANGLE_BITS = 12;
    localparam int RATIO_BITS = 13;
    localparam int FRAC_BITS  = 6;
    localparam int SEG_BITS   = RATIO_BITS - FRAC_BITS;
    localparam int OCT_BITS   = 10;
    localparam int DIFF_BITS  = 4;
    localparam int ROM_DEPTH  = 65;

    localparam logic [OCT_BITS-1:0]   OCT_ANGLE  = 10'd512;
    localparam logic [ANGLE_BITS-1:0] QUAD_ANGLE = 12'd1024;
    localparam logic [ANGLE_BITS-1:0] HALF_ANGLE = 12'd2048;

    localparam logic [OCT_BITS-1:0] ATAN_ROM [0:ROM_DEPTH-1] = '{
        10'd0,   10'd10,  10'd20,  10'd31,  10'd41,  10'd51,  10'd61,  10'd71,
        10'd81,  10'd91,  10'd101, 10'd111, 10'd121, 10'd131, 10'd140, 10'd150,
        10'd160, 10'd169, 10'd179, 10'd188, 10'd197, 10'd207, 10'd216, 10'd225,
        10'd234, 10'd243, 10'd252, 10'd260, 10'd269, 10'd277, 10'd286, 10'd294,
        10'd302, 10'd310, 10'd318, 10'd326, 10'd334, 10'd342, 10'd349, 10'd357,
        10'd364, 10'd371, 10'd379, 10'd386, 10'd393, 10'd399, 10'd406, 10'd413,
        10'd419, 10'd426, 10'd432, 10'd439, 10'd445, 10'd451, 10'd457, 10'd463,
        10'd469, 10'd474, 10'd480, 10'd486, 10'd491, 10'd496, 10'd502, 10'd507,
        10'd512
    };

    typedef struct packed {
        logic swap;
        logic down;
        logic x_neg;
        logic zero;
    } t_flags;

    function automatic logic [OCT_BITS-1:0] atan_lookup(input logic [SEG_BITS-1:0] idx);
        logic [OCT_BITS-1:0] val;
        val = OCT_ANGLE;
        if (idx < SEG_BITS'(ROM_DEPTH)) begin
            val = ATAN_ROM[idx];
        end
        return val;
    endfunction

endpackage

[sv/vector_angle_lut.sv]
// vector_angle_lut: clockwise angle from straight up of a screen vector, 4096 per turn
// fold, 13-stage restoring divider, table interpolation, unfold; uses vang_pkg
//
//  channel | signals                       | direction
//  --------+-------------------------------+----------
//  in      | i_valid, o_stall, i_dx, i_dy  | into block
//  out     | o_valid, i_stall, o_angle     | out of block
//
// one word per cycle while the output is not stalled; stages in order: fold, 13 divider steps
// (one quotient bit each), table read, interpolate and unfold
// reset is synchronous, active low, and empties the pipeline
// each stage advances when it is empty or the stage after it advances, so
// bubbles close up and o_stall rises only when every stage holds a word
`timescale 1ns / 1ps

module vector_angle_lut #(
    parameter int COORD_BITS = vang_pkg::COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_BITS-1:0]          i_dx,
    input  logic signed [COORD_BITS-1:0]          i_dy,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [vang_pkg::ANGLE_BITS-1:0]       o_angle
);

    localparam int NDIV = vang_pkg::RATIO_BITS;
    localparam int NS   = NDIV + 3;
    localparam int LK   = NDIV + 1;
    localparam int OS   = NDIV + 2;
    localparam int QB   = vang_pkg::RATIO_BITS;
    localparam int AB   = vang_pkg::ANGLE_BITS;
    localparam int OB   = vang_pkg::OCT_BITS;
    localparam int FB   = vang_pkg::FRAC_BITS;
    localparam int SB   = vang_pkg::SEG_BITS;
    localparam int DB   = vang_pkg::DIFF_BITS;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    // stage 0 is the fold, stages 1..NDIV the divider steps
    logic [COORD_BITS-1:0] r_rem   [0:NDIV];
    logic [COORD_BITS-1:0] r_large [0:NDIV];
    logic [QB-1:0]         r_quot  [0:NDIV];
    vang_pkg::t_flags      r_flags [0:NDIV];

    logic [OB-1:0]    r_lo;
    logic [DB-1:0]    r_diff;
    logic [FB-1:0]    r_frac;
    vang_pkg::t_flags r_lk_flags;
    logic [AB-1:0]    r_angle;

    // handshake chain
    assign w_en[NS-1] = !r_v[NS-1] || !i_stall;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign w_en[s] = !r_v[s] || w_en[s+1];
    end
    assign o_stall = !w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_angle = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // fold into one octant
    logic [COORD_BITS-1:0] w_dxu, w_dyu, w_mx, w_my;
    vang_pkg::t_flags      w_flags;

    always_comb begin
        w_dxu = i_dx;
        w_dyu = i_dy;
        w_mx  = w_dxu[COORD_BITS-1] ? (~w_dxu + 1'b1) : w_dxu;
        w_my  = w_dyu[COORD_BITS-1] ? (~w_dyu + 1'b1) : w_dyu;
        w_flags.swap  = w_mx > w_my;
        w_flags.down  = !w_dyu[COORD_BITS-1] && (w_dyu != '0);
        w_flags.x_neg = w_dxu[COORD_BITS-1];
        w_flags.zero  = (w_mx == '0) && (w_my == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0]   <= w_flags.swap ? w_my : w_mx;
            r_large[0] <= w_flags.swap ? w_mx : w_my;
            r_quot[0]  <= '0;
            r_flags[0] <= w_flags;
        end
    end

    // restoring division of (small << 12) by large, one quotient bit per stage
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [COORD_BITS:0]   w_trial;
        logic                  w_bit;
        logic [COORD_BITS-1:0] w_rem;

        if (k == 0) begin : g_first
            assign w_trial = {1'b0, r_rem[k]};
        end else begin : g_next
            assign w_trial = {r_rem[k], 1'b0};
        end

        always_comb begin
            w_bit = w_trial >= {1'b0, r_large[k]};
            w_rem = w_bit ? COORD_BITS'(w_trial - {1'b0, r_large[k]})
                          : w_trial[COORD_BITS-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k+1]) begin
                r_rem[k+1]   <= w_rem;
                r_large[k+1] <= r_large[k];
                r_quot[k+1]  <= {r_quot[k][QB-2:0], w_bit};
                r_flags[k+1] <= r_flags[k];
            end
        end
    end

    // table read
    logic [SB-1:0] w_seg;
    logic [OB-1:0] w_lo, w_hi;

    always_comb begin
        w_seg = r_quot[NDIV][QB-1:FB];
        w_lo  = vang_pkg::atan_lookup(w_seg);
        w_hi  = vang_pkg::atan_lookup(w_seg + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LK]) begin
            r_lo       <= w_lo;
            r_diff     <= r_quot[NDIV][QB-1] ? '0 : DB'(w_hi - w_lo);
            r_frac     <= r_quot[NDIV][FB-1:0];
            r_lk_flags <= r_flags[NDIV];
        end
    end

    // interpolate and unfold by quadrant
    logic [DB+FB-1:0] w_prod;
    logic [OB-1:0]    w_oct;
    logic [AB-1:0]    w_a1, w_a2, w_a3;

    always_comb begin
        w_prod = DB'(r_diff) * FB'(r_frac);
        w_oct  = r_lo + OB'(w_prod[DB+FB-1:FB]);
        w_a1   = r_lk_flags.swap ? (vang_pkg::QUAD_ANGLE - AB'(w_oct)) : AB'(w_oct);
        w_a2   = r_lk_flags.down ? (vang_pkg::HALF_ANGLE - w_a1) : w_a1;
        w_a3   = r_lk_flags.x_neg ? (AB'(0) - w_a2) : w_a2;
        if (r_lk_flags.zero) begin
            w_a3 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[OS]) begin
            r_angle <= w_a3;
        end
    end

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for vector_angle_lut, directed table then random vectors
// predicts each angle not fixed in the directed table from the folded octant ratio and the package arctangent table
// depends on vang_pkg and vector_angle_lut
`timescale 1ns / 1ps

module tb_top;

    localparam int CB         = vang_pkg::COORD_BITS;
    localparam int AB         = vang_pkg::ANGLE_BITS;
    localparam int N_RANDOM   = 1450;
    localparam int N_DIRECTED = 22;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN      = 40;
    localparam int HOLD_LEN   = 100;

    typedef struct packed {
        logic signed [CB-1:0] dx;
        logic signed [CB-1:0] dy;
        logic                 fixed;
        logic [AB-1:0]        angle;
    } t_vec_row;

    typedef struct packed {
        logic signed [CB-1:0] dx;
        logic signed [CB-1:0] dy;
        logic [AB-1:0]        angle;
    } t_angle_exp;

    localparam t_vec_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{16'sd0,      16'sd0,      1'b1, 12'd0},
        '{16'sd0,      -16'sd1,     1'b1, 12'd0},
        '{16'sd1,      16'sd0,      1'b1, 12'd1024},
        '{16'sd0,      16'sd1,      1'b1, 12'd2048},
        '{-16'sd1,     16'sd0,      1'b1, 12'd3072},
        '{16'sd5,      -16'sd5,     1'b1, 12'd512},
        '{16'sd5,      16'sd5,      1'b1, 12'd1536},
        '{-16'sd5,     16'sd5,      1'b1, 12'd2560},
        '{-16'sd5,     -16'sd5,     1'b1, 12'd3584},
        '{-16'sd1,     -16'sd1,     1'b1, 12'd3584},
        '{16'sd0,      16'sh8000,   1'b1, 12'd0},
        '{16'sd32767,  16'sd0,      1'b1, 12'd1024},
        '{16'sh8000,   16'sd0,      1'b1, 12'd3072},
        '{16'sd0,      16'sd32767,  1'b1, 12'd2048},
        '{16'sh8000,   16'sh8000,   1'b1, 12'd3584},
        '{16'sd32767,  16'sd32767,  1'b1, 12'd1536},
        '{16'sh8000,   16'sd32767,  1'b0, 12'd0},
        '{16'sd32767,  16'sh8000,   1'b0, 12'd0},
        '{16'sd1,      16'sh8000,   1'b0, 12'd0},
        '{16'sh8000,   16'sd1,      1'b0, 12'd0},
        '{16'sd3,      -16'sd7,     1'b0, 12'd0},
        '{-16'sd100,   16'sd37,     1'b0, 12'd0}
    };

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CB-1:0] i_dx    = '0;
    logic signed [CB-1:0] i_dy    = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [AB-1:0]        o_angle;

    t_vec_row   vec_q[$];
    t_angle_exp angle_q[$];
    t_vec_row   cur_vec;
    int         n_sent     = 0;
    int         n_total    = 0;
    int         n_bad      = 0;
    int         idle_count = 0;
    int         hold_count = 0;
    logic       hold_done  = 1'b0;

    vector_angle_lut #(
        .COORD_BITS(CB)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_dx    (i_dx),
        .i_dy    (i_dy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_angle (o_angle)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // arctangent of small/large within one octant, 0..512
    function automatic int octant_atan(input int small_mag, input int large_mag);
        int ratio;
        int seg;
        int frac;
        int lo;
        int hi;
        if (large_mag == 0) begin
            return 0;
        end
        ratio = (small_mag << 12) / large_mag;
        seg   = ratio >> 6;
        frac  = ratio & 63;
        if (seg >= 64) begin
            return 512;
        end
        lo = int'(vang_pkg::ATAN_ROM[seg]);
        hi = int'(vang_pkg::ATAN_ROM[seg + 1]);
        return lo + (((hi - lo) * frac) >> 6);
    endfunction

    function automatic logic [AB-1:0] vector_angle(input logic signed [CB-1:0] dx,
                                                   input logic signed [CB-1:0] dy);
        int sx;
        int sy;
        int mx;
        int my;
        int a;
        sx = int'(dx);
        sy = int'(dy);
        mx = (sx < 0) ? -sx : sx;
        my = (sy < 0) ? -sy : sy;
        if (mx == 0 && my == 0) begin
            return '0;
        end
        if (mx <= my) begin
            a = octant_atan(mx, my);
        end else begin
            a = 1024 - octant_atan(my, mx);
        end
        if (sy > 0) begin
            a = 2048 - a;
        end
        if (sx < 0) begin
            a = (4096 - a) & 4095;
        end
        return AB'(a & 4095);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic t_vec_row random_vec();
        t_vec_row v;
        int       a;
        int       b;
        int       large_mag;
        int       k;
        v = '0;
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                a = rand_coord();
                b = rand_coord();
            end
            3: begin
                a = int'($urandom_range(0, 16)) - 8;
                b = int'($urandom_range(0, 16)) - 8;
            end
            4: begin
                a = rand_coord();
                b = ($urandom_range(0, 1) ? a : -a) + int'($urandom_range(0, 8)) - 4;
            end
            5: begin
                a = $urandom_range(0, 1) ? rand_coord() : ($urandom_range(0, 1) ? 32767 : -32768);
                b = 0;
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: a = -32768;
                    1: a = 32767;
                    2: a = -32767;
                    default: a = 0;
                endcase
                b = rand_coord();
            end
            default: begin
                // ratios landing on or next to table segment boundaries
                large_mag = int'($urandom_range(1, 32767));
                k         = int'($urandom_range(0, 64));
                a         = large_mag;
                b         = (large_mag * k) >> 6;
                b         = b + int'($urandom_range(0, 2)) - 1;
                if (b < 0) begin
                    b = 0;
                end
                if (b > a) begin
                    b = a;
                end
                if ($urandom_range(0, 1)) begin
                    a = -a;
                end
                if ($urandom_range(0, 1)) begin
                    b = -b;
                end
            end
        endcase
        if ($urandom_range(0, 1)) begin
            v.dx = CB'(a);
            v.dy = CB'(b);
        end else begin
            v.dx = CB'(b);
            v.dy = CB'(a);
        end
        return v;
    endfunction

    function automatic int send_idle_pct(input int sent);
        if (sent < 490) begin
            return 28;
        end else if (sent < 980) begin
            return 69;
        end
        return 0;
    endfunction

    function automatic int recv_idle_pct(input int sent);
        if (sent < 490) begin
            return 69;
        end else if (sent < 980) begin
            return 28;
        end
        return 0;
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                angle_q.push_back('{cur_vec.dx, cur_vec.dy,
                                    cur_vec.fixed ? cur_vec.angle
                                                  : vector_angle(cur_vec.dx, cur_vec.dy)});
                n_sent <= n_sent + 1;
            end
            if (!(i_valid && o_stall)) begin
                if (vec_q.size() > 0 && int'($urandom_range(0, 99)) >= send_idle_pct(n_sent)) begin
                    cur_vec = vec_q.pop_front();
                    i_valid <= 1'b1;
                    i_dx    <= cur_vec.dx;
                    i_dy    <= cur_vec.dy;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side stall, with one long hold-off to back the pipeline up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            i_stall    <= 1'b1;
        end else if (!hold_done && n_sent >= 1100) begin
            hold_done  <= 1'b1;
            hold_count <= HOLD_LEN;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= int'($urandom_range(0, 99)) < recv_idle_pct(n_sent);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_angle_exp exp_word;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angle_q.size() == 0) begin
                n_bad <= n_bad + 1;
                if (n_bad < 10) begin
                    $display("unexpected word: angle %0d", o_angle);
                end
            end else begin
                exp_word = angle_q.pop_front();
                if (o_angle !== exp_word.angle) begin
                    n_bad <= n_bad + 1;
                    if (n_bad < 10) begin
                        $display("angle error: dx %0d dy %0d expected %0d got %0d",
                                 exp_word.dx, exp_word.dy, exp_word.angle, o_angle);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_count <= 0;
            end else begin
                idle_count <= idle_count + 1;
            end
            if (idle_count >= IDLE_LIMIT) begin
                $display("vector_angle_lut: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_vec_row v;
        foreach (DIRECTED_ROWS[i]) begin
            vec_q.push_back(DIRECTED_ROWS[i]);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            v = random_vec();
            vec_q.push_back(v);
        end
        n_total = vec_q.size();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_sent < n_total) @(posedge i_clk);
        while (angle_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("vector_angle_lut: match");
        end else begin
            $display("vector_angle_lut: mismatch");
        end
        $finish;
    end

endmodule
